/* design/tla_pkg.sv */
// tla_pkg: shared types and constants of the terminal line assembler
// used by tla_ctrl, tla_datapath and terminal_line_assembler; no dependencies
`timescale 1ns / 1ps

package tla_pkg;

    localparam int LEN_CMP_W   = 9;
    localparam int CHUNK_W     = 64;
    localparam int COUNT_W     = 4;
    localparam int COL_W       = 7;
    localparam int TDATA_OUT_W = 72;

    localparam logic [COL_W-1:0]   END_COUNT   = 7'd80;
    localparam logic [COUNT_W-1:0] CHUNK_MAX   = 4'd8;
    localparam logic [7:0]         PARITY_MASK = 8'h7F;
    localparam logic [7:0]         CH_CR       = 8'h0D;
    localparam logic [7:0]         CH_ESC      = 8'h1B;
    localparam logic [7:0]         CH_SPACE    = 8'h20;
    localparam logic [7:0]         CH_SEMI     = 8'h3B;
    localparam logic [7:0]         CH_A        = 8'h41;
    localparam logic [7:0]         PRINT_LO    = 8'h20;
    localparam logic [7:0]         PRINT_HI    = 8'h7E;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_SKIP1 = 2'd1,
        ESC_SKIP2 = 2'd2
    } esc_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PACK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic pack;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic emit_req;
        logic chunk_stop;
        logic line_done;
        logic out_free;
    } status_t;

endpackage

/* design/terminal_line_assembler.sv */
// terminal_line_assembler: top level joining controller and datapath
// depends on tla_pkg, tla_ctrl and tla_datapath
`timescale 1ns / 1ps

// usage
//   slave side takes one received byte per word on s_tdata; master side gives
//   line chunks of up to eight characters, m_tlast on the final chunk of a line
//   cfg_wr_en / cfg_wr_data set parity stripping (reset value 1); write only
//   while idle
// intake and readout
//   a byte that does not end a line is taken in idle; s_tready stays high
//   a byte that ends a non-blank line starts a readout of the line store:
//   per chunk a fetch, a pack step for each stored character and an output
//   load, paced by the single read port of the line store
// reset
//   clears line length, column and escape state; the line store holds no
//   reset value and needs no clearing pass
// stall
//   a chunk waits in the output register; readout pauses until it is taken

module terminal_line_assembler
    import tla_pkg::*;
#(
    parameter int LINE_LIMIT = 80
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,    // [63:0] line_chunk, [67:64] chunk_bytes
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data
);

    cmd_t               cmd;
    status_t            status;
    logic [CHUNK_W-1:0] line_chunk;
    logic [COUNT_W-1:0] chunk_bytes;

    tla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tla_datapath #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .line_chunk  (line_chunk),
        .chunk_bytes (chunk_bytes),
        .line_last   (m_tlast)
    );

    assign m_tdata = {{(TDATA_OUT_W - CHUNK_W - COUNT_W){1'b0}}, chunk_bytes, line_chunk};

endmodule

/* design/tla_ctrl.sv */
// tla_ctrl: controller of the terminal line assembler
// sequences word intake and line readout; depends on tla_pkg
`timescale 1ns / 1ps

module tla_ctrl
    import tla_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.emit_req)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PACK;
            end
            ST_PACK:
            begin
                if (status.chunk_stop)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = status.line_done ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_PACK:
            begin
                cmd.pack = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/tla_datapath.sv */
// tla_datapath: line state, line store memory, chunk packer and output register
// driven by tla_ctrl commands; depends on tla_pkg
`timescale 1ns / 1ps

module tla_datapath
    import tla_pkg::*;
#(
    parameter int LINE_LIMIT = 80
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [CHUNK_W-1:0] line_chunk,
    output logic [COUNT_W-1:0] chunk_bytes,
    output logic               line_last
);

    localparam int LEN_W  = $clog2(LINE_LIMIT + 1);
    localparam int ADDR_W = $clog2(LINE_LIMIT);

    logic [7:0] line_store [LINE_LIMIT];
    logic [7:0] rd_data_reg;

    logic               strip_reg;
    logic [LEN_W-1:0]   len_reg,      len_next;
    logic [LEN_W-1:0]   trim_reg,     trim_next;
    logic [COL_W-1:0]   col_reg,      col_next;
    esc_phase_t         phase_reg,    phase_next;
    logic [LEN_W-1:0]   emit_len_reg, emit_len_next;
    logic [LEN_W-1:0]   ptr_reg,      ptr_next;
    logic [COUNT_W-1:0] cnt_reg,      cnt_next;
    logic [CHUNK_W-1:0] chunk_reg,    chunk_next;

    logic               out_valid_reg, out_valid_next;
    logic [CHUNK_W-1:0] out_chunk_reg;
    logic [COUNT_W-1:0] out_bytes_reg;
    logic               out_last_reg;

    logic [7:0]       b;
    logic             in_escape;
    logic             printable;
    logic             store_ok;
    logic [LEN_W-1:0] len_upd;
    logic [LEN_W-1:0] trim_upd;
    logic [COL_W-1:0] col_upd;
    logic [COL_W-1:0] col_cand;
    logic [LEN_W-1:0] end_trim;
    logic             line_end;
    logic             wr_en;
    logic             rd_issue;
    logic             out_load;

    // byte classification and line bookkeeping
    always_comb
    begin
        b         = strip_reg ? (rx_byte & PARITY_MASK) : rx_byte;
        in_escape = (phase_reg != ESC_NONE);
        printable = (b inside {[PRINT_LO:PRINT_HI]}) && (b != CH_SEMI);
        store_ok  = (len_reg < LEN_W'(LINE_LIMIT));
        len_upd   = store_ok ? len_reg + 1'b1 : len_reg;
        trim_upd  = (store_ok && (b != CH_SPACE)) ? len_reg + 1'b1 : trim_reg;
        col_upd   = col_reg + 1'b1;
        col_cand  = printable ? col_upd : col_reg;
        end_trim  = printable ? trim_upd : trim_reg;
        line_end  = !in_escape && (!printable || (col_upd >= END_COUNT)
                    || (LEN_CMP_W'(len_upd) >= LEN_CMP_W'(END_COUNT)));
        wr_en     = cmd.accept && !in_escape && printable && store_ok;
    end

    assign status.emit_req   = line_end && (end_trim != '0);
    assign status.line_done  = (ptr_reg == emit_len_reg);
    assign status.chunk_stop = (cnt_reg == CHUNK_MAX - 1'b1) || (ptr_reg == emit_len_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign rd_issue = cmd.fetch || (cmd.pack && !status.chunk_stop);
    assign out_load = cmd.flush && status.out_free;

    always_comb
    begin
        len_next       = len_reg;
        trim_next      = trim_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        emit_len_next  = emit_len_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        chunk_next     = chunk_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            if (in_escape)
            begin
                phase_next = ((phase_reg == ESC_SKIP1) && (b == CH_A)) ? ESC_SKIP2 : ESC_NONE;
            end
            else
            begin
                if (printable)
                begin
                    len_next  = len_upd;
                    trim_next = trim_upd;
                    col_next  = col_upd;
                end
                if (line_end)
                begin
                    len_next      = '0;
                    trim_next     = '0;
                    emit_len_next = end_trim;
                    ptr_next      = '0;
                    cnt_next      = '0;
                    chunk_next    = '0;
                    if ((b == CH_CR) || (col_cand >= END_COUNT))
                    begin
                        col_next = '0;
                    end
                    if (b == CH_ESC)
                    begin
                        phase_next = ESC_SKIP1;
                    end
                end
            end
        end

        if (rd_issue)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.pack)
        begin
            chunk_next[{cnt_reg[2:0], 3'b000} +: 8] = rd_data_reg;
            cnt_next = cnt_reg + 1'b1;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            chunk_next     = '0;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg     <= 1'b1;
            len_reg       <= '0;
            trim_reg      <= '0;
            col_reg       <= '0;
            phase_reg     <= ESC_NONE;
            emit_len_reg  <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                strip_reg <= cfg_wr_data;
            end
            len_reg       <= len_next;
            trim_reg      <= trim_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            emit_len_reg  <= emit_len_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chunk_reg <= chunk_next;
        if (out_load)
        begin
            out_chunk_reg <= chunk_reg;
            out_bytes_reg <= cnt_reg;
            out_last_reg  <= status.line_done;
        end
    end

    // line store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_store[len_reg[ADDR_W-1:0]] <= b;
        end
        if (rd_issue)
        begin
            rd_data_reg <= line_store[ptr_reg[ADDR_W-1:0]];
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_chunk  = out_chunk_reg;
    assign chunk_bytes = out_bytes_reg;
    assign line_last   = out_last_reg;

    a_trim_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        trim_reg <= len_reg)
        else $error("trimmed length beyond line length");

    a_col_below_end: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < END_COUNT)
        else $error("column count reached end without reset");

    a_ptr_within_line: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pack |-> (ptr_reg <= emit_len_reg) && (cnt_reg < CHUNK_MAX))
        else $error("readout pointer or chunk count out of range");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (out_bytes_reg != '0))
        else $error("empty chunk loaded into output");

endmodule
